### src/box_overlap_suppress_filter_defines.svh
// Assertion helpers used by the filter's top-level RTL.
`ifndef BOX_OVERLAP_SUPPRESS_FILTER_DEFINES_SVH
`define BOX_OVERLAP_SUPPRESS_FILTER_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define BOSF_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// A condition that must hold in the cycle after the antecedent.
`define BOSF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/bosf_pkg.sv
package bosf_pkg;

    localparam int unsigned COORD_W = 16;
    localparam int unsigned SIDE_W  = 15;
    localparam int unsigned AREA_W  = 2 * SIDE_W;
    localparam int unsigned THR_W   = 17;
    localparam int unsigned FRAC_W  = 16;
    localparam int unsigned PROD_W  = THR_W + AREA_W;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_LOAD   = 2'd1,
        MODE_QUERY  = 2'd2,
        MODE_UNUSED = 2'd3
    } t_mode;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic        [SIDE_W-1:0]  w;
        logic        [SIDE_W-1:0]  h;
    } t_box;

    // Per-reference outcome leaving the overlap unit.
    typedef struct packed {
        logic vld;
        logic hit;
    } t_score;

endpackage

### src/bosf_ref_mem.sv
module bosf_ref_mem #(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW    = 5
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  bosf_pkg::t_box  i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output bosf_pkg::t_box  o_rdata
);
    import bosf_pkg::*;

    t_box r_mem [DEPTH];
    t_box r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/bosf_overlap_unit.sv
module bosf_overlap_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_vld,
    input  bosf_pkg::t_box             i_ref,
    input  bosf_pkg::t_box             i_query,
    input  logic [bosf_pkg::THR_W-1:0] i_thr,
    output bosf_pkg::t_score           o_score
);
    import bosf_pkg::*;

    // Stage one: edge arithmetic.
    logic signed [COORD_W:0]   q_x0, q_x1, q_y0, q_y1;
    logic signed [COORD_W:0]   f_x0, f_x1, f_y0, f_y1;
    logic signed [COORD_W:0]   lo_x, hi_x, lo_y, hi_y;
    logic signed [COORD_W+1:0] dx, dy;
    logic [SIDE_W-1:0]         n_ox, n_oy;
    logic [SIDE_W-1:0]         r_ox, r_oy, r_rw, r_rh;
    logic                      r_vld1;

    // Stage two: areas.
    logic [AREA_W-1:0] r_inter2, r_aq, r_ar;
    logic              r_vld2;

    // Stage three: scaled threshold.
    logic [AREA_W-1:0] amin;
    logic [AREA_W-1:0] r_inter3;
    logic [PROD_W-1:0] r_prod;
    logic              r_zero;
    logic              r_vld3;

    // Stage four: decision.
    logic r_hit;
    logic r_vld4;

    always_comb begin
        q_x0 = {i_query.x[COORD_W-1], i_query.x};
        q_y0 = {i_query.y[COORD_W-1], i_query.y};
        f_x0 = {i_ref.x[COORD_W-1], i_ref.x};
        f_y0 = {i_ref.y[COORD_W-1], i_ref.y};
        q_x1 = q_x0 + signed'({2'b00, i_query.w});
        q_y1 = q_y0 + signed'({2'b00, i_query.h});
        f_x1 = f_x0 + signed'({2'b00, i_ref.w});
        f_y1 = f_y0 + signed'({2'b00, i_ref.h});
        lo_x = (q_x0 > f_x0) ? q_x0 : f_x0;
        lo_y = (q_y0 > f_y0) ? q_y0 : f_y0;
        hi_x = (q_x1 < f_x1) ? q_x1 : f_x1;
        hi_y = (q_y1 < f_y1) ? q_y1 : f_y1;
        dx   = {hi_x[COORD_W], hi_x} - {lo_x[COORD_W], lo_x};
        dy   = {hi_y[COORD_W], hi_y} - {lo_y[COORD_W], lo_y};
        // A positive overlap never exceeds the narrower side, so it fits a side width.
        n_ox = (!dx[COORD_W+1] && (dx != '0)) ? dx[SIDE_W-1:0] : '0;
        n_oy = (!dy[COORD_W+1] && (dy != '0)) ? dy[SIDE_W-1:0] : '0;
        amin = (r_aq < r_ar) ? r_aq : r_ar;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
            r_vld4 <= r_vld3;
        end
        r_ox     <= n_ox;
        r_oy     <= n_oy;
        r_rw     <= i_ref.w;
        r_rh     <= i_ref.h;
        r_inter2 <= AREA_W'(r_ox) * AREA_W'(r_oy);
        r_ar     <= AREA_W'(r_rw) * AREA_W'(r_rh);
        r_aq     <= AREA_W'(i_query.w) * AREA_W'(i_query.h);
        r_inter3 <= r_inter2;
        r_zero   <= (amin == '0);
        r_prod   <= PROD_W'(i_thr) * PROD_W'(amin);
        r_hit    <= !r_zero && ({1'b0, r_inter3, {FRAC_W{1'b0}}} > r_prod);
    end

    assign o_score.vld = r_vld4;
    assign o_score.hit = r_hit;

endmodule

### src/box_overlap_suppress_filter.sv
// A clear or load leaves the block idle; it can take a new request in the following cycle.
// A query reads the stored references in turn; the overlap unit scores one reference a cycle.
// The request side stalls until the result sits in the output register.
// Synchronous active-low reset empties the store and sets the threshold to one half.
`include "box_overlap_suppress_filter_defines.svh"

module box_overlap_suppress_filter #(
    parameter int unsigned MAX_REFS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [1:0]                     i_mode,
    input  logic signed [15:0]             i_box_x,
    input  logic signed [15:0]             i_box_y,
    input  logic [14:0]                    i_box_width,
    input  logic [14:0]                    i_box_height,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_suppressed,
    output logic [5:0]                     o_refs_checked,
    input  logic                           i_cfg_we,
    input  logic [bosf_pkg::THR_W-1:0]     i_cfg_wdata
);
    import bosf_pkg::*;

    localparam int unsigned AW = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
    localparam int unsigned CW = $clog2(MAX_REFS + 1);
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(32768);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    t_state           r_state;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    r_issue;
    logic [CW-1:0]    r_done;
    logic             r_hit;
    logic             r_rd_vld;
    logic [THR_W-1:0] r_thr;
    t_box             r_query;
    logic             r_out_valid;
    logic             r_suppressed;
    logic [5:0]       r_refs_checked;

    t_box   in_box;
    t_box   rd_box;
    t_score w_score;
    logic   in_acc;
    logic   load_we;
    logic   rd_en;
    logic   out_free;

    assign in_box.x = i_box_x;
    assign in_box.y = i_box_y;
    assign in_box.w = i_box_width;
    assign in_box.h = i_box_height;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && (r_state == ST_IDLE);
    assign load_we    = in_acc && (i_mode == MODE_LOAD) && (r_count != CW'(MAX_REFS));
    assign rd_en      = (r_state == ST_SCAN) && (r_issue != r_count);
    assign out_free   = !r_out_valid || !i_out_stall;

    bosf_ref_mem #(
        .DEPTH (MAX_REFS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (in_box),
        .i_re    (rd_en),
        .i_raddr (r_issue[AW-1:0]),
        .o_rdata (rd_box)
    );

    bosf_overlap_unit u_overlap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_rd_vld),
        .i_ref   (rd_box),
        .i_query (r_query),
        .i_thr   (r_thr),
        .o_score (w_score)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_issue     <= '0;
            r_done      <= '0;
            r_hit       <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_thr       <= THR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= rd_en;
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (r_out_valid && !i_out_stall && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        unique case (i_mode)
                            MODE_CLEAR: begin
                                r_count <= '0;
                            end
                            MODE_LOAD: begin
                                if (load_we) begin
                                    r_count <= r_count + 1'b1;
                                end
                            end
                            MODE_QUERY: begin
                                r_query <= in_box;
                                r_issue <= '0;
                                r_done  <= '0;
                                r_hit   <= 1'b0;
                                r_state <= ST_SCAN;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (rd_en) begin
                        r_issue <= r_issue + 1'b1;
                    end
                    if (w_score.vld) begin
                        r_done <= r_done + 1'b1;
                        r_hit  <= r_hit | w_score.hit;
                    end
                    if (r_done == r_count) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // Hold the verdict until the output register has room.
                    if (out_free) begin
                        r_out_valid    <= 1'b1;
                        r_suppressed   <= r_hit;
                        r_refs_checked <= 6'(r_count);
                        r_state        <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_suppressed   = r_suppressed;
    assign o_refs_checked = r_refs_checked;

    `BOSF_ASSERT_ALWAYS(a_count_range, r_count <= CW'(MAX_REFS), "reference count beyond depth")
    `BOSF_ASSERT_ALWAYS(a_done_le_issue, r_done <= r_issue, "more scores than reads issued")
    `BOSF_ASSERT_ALWAYS(a_score_in_scan, !w_score.vld || r_state == ST_SCAN, "stray score")
    `BOSF_ASSERT_NEXT(a_result_out, r_state == ST_DONE && out_free, o_out_valid && r_state == ST_IDLE, "result not registered")

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;

    import bosf_pkg::*;

    localparam int unsigned MAX_REFS = 32;

    localparam int unsigned DIRECTED_ROWS = 21;
    localparam int unsigned THR_PHASES    = 8;
    localparam int unsigned PHASE_ITEMS   = 130;

    typedef struct packed {
        logic       suppressed;
        logic [5:0] refs;
    } t_verdict;

    typedef struct packed {
        logic [1:0] mode;
        t_box       box;
        logic       typed;
        t_verdict   verdict;
    } t_req_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [1:0]        i_mode = MODE_CLEAR;
    logic signed [15:0] i_box_x = '0;
    logic signed [15:0] i_box_y = '0;
    logic [14:0]       i_box_width = '0;
    logic [14:0]       i_box_height = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic              o_suppressed;
    logic [5:0]        o_refs_checked;
    logic              i_cfg_we = 1'b0;
    logic [THR_W-1:0]  i_cfg_wdata = '0;

    // Local copy of the filter state.
    t_box              ref_store [MAX_REFS];
    int unsigned       ref_total = 0;
    logic [THR_W-1:0]  threshold = 17'd32768;

    t_verdict          awaited_verdicts [$];
    t_req_row          directed_rows [DIRECTED_ROWS];
    int unsigned       thr_plan [THR_PHASES];
    int unsigned       sent_items = 0;
    int unsigned       mismatches = 0;
    int                sink_wait = 0;
    bit                gaps_on = 1'b1;

    box_overlap_suppress_filter #(
        .MAX_REFS(MAX_REFS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_box_x       (i_box_x),
        .i_box_y       (i_box_y),
        .i_box_width   (i_box_width),
        .i_box_height  (i_box_height),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_suppressed  (o_suppressed),
        .o_refs_checked(o_refs_checked),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    function automatic bit overlap_exceeds(t_box q, t_box r);
        longint ox;
        longint oy;
        longint inter;
        longint aq;
        longint ar;
        longint amin;
        longint qx1;
        longint qy1;
        longint rx1;
        longint ry1;
        longint lo;
        qx1 = longint'($signed(q.x)) + longint'(q.w);
        qy1 = longint'($signed(q.y)) + longint'(q.h);
        rx1 = longint'($signed(r.x)) + longint'(r.w);
        ry1 = longint'($signed(r.y)) + longint'(r.h);
        lo = ($signed(q.x) > $signed(r.x)) ? longint'($signed(q.x)) : longint'($signed(r.x));
        ox = ((qx1 < rx1) ? qx1 : rx1) - lo;
        lo = ($signed(q.y) > $signed(r.y)) ? longint'($signed(q.y)) : longint'($signed(r.y));
        oy = ((qy1 < ry1) ? qy1 : ry1) - lo;
        if (ox < 0) ox = 0;
        if (oy < 0) oy = 0;
        inter = ox * oy;
        aq = longint'(q.w) * longint'(q.h);
        ar = longint'(r.w) * longint'(r.h);
        amin = (aq < ar) ? aq : ar;
        if (amin == 0) return 1'b0;
        return (inter * 65536) > (longint'(threshold) * amin);
    endfunction

    // Applies one accepted request to the local state; queries yield a verdict.
    function automatic bit predict_suppression(logic [1:0] op, t_box b, output t_verdict v);
        v = '0;
        case (op)
            MODE_CLEAR: begin
                ref_total = 0;
            end
            MODE_LOAD: begin
                if (ref_total < MAX_REFS) begin
                    ref_store[ref_total] = b;
                    ref_total++;
                end
            end
            MODE_QUERY: begin
                for (int unsigned i = 0; i < ref_total; i++)
                    if (overlap_exceeds(b, ref_store[i])) v.suppressed = 1'b1;
                v.refs = ref_total[5:0];
                return 1'b1;
            end
            default: begin
            end
        endcase
        return 1'b0;
    endfunction

    function automatic t_box random_box();
        t_box b;
        int t;
        if ($urandom_range(0, 7) == 0) begin
            b.x = 16'($urandom);
            b.y = 16'($urandom);
            b.w = 15'($urandom);
            b.h = 15'($urandom);
        end else begin
            t = int'($urandom_range(0, 128)) - 64;
            b.x = t[15:0];
            t = int'($urandom_range(0, 128)) - 64;
            b.y = t[15:0];
            b.w = ($urandom_range(0, 9) == 0) ? 15'd0 : 15'($urandom_range(1, 48));
            b.h = ($urandom_range(0, 9) == 0) ? 15'd0 : 15'($urandom_range(1, 48));
        end
        return b;
    endfunction

    // A query close to a stored reference, so that overlaps near the threshold are common.
    function automatic t_box jittered_box(t_box r);
        t_box b;
        int t;
        t = int'($signed(r.x)) + int'($urandom_range(0, 8)) - 4;
        b.x = t[15:0];
        t = int'($signed(r.y)) + int'($urandom_range(0, 8)) - 4;
        b.y = t[15:0];
        t = int'(r.w) + int'($urandom_range(0, 8)) - 4;
        b.w = (t < 0) ? 15'd0 : (t > 32767) ? 15'h7FFF : t[14:0];
        t = int'(r.h) + int'($urandom_range(0, 8)) - 4;
        b.h = (t < 0) ? 15'd0 : (t > 32767) ? 15'h7FFF : t[14:0];
        return b;
    endfunction

    task automatic issue_request(input logic [1:0] op, input t_box b, input bit typed,
                                 input t_verdict typed_verdict);
        int gap;
        t_verdict v;
        bit ignored;
        gap = gaps_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_mode       <= op;
        i_box_x      <= b.x;
        i_box_y      <= b.y;
        i_box_width  <= b.w;
        i_box_height <= b.h;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        ignored = (op == MODE_UNUSED) || (op == MODE_LOAD && ref_total >= MAX_REFS);
        if (!ignored) sent_items++;
        if (predict_suppression(op, b, v))
            awaited_verdicts.insert(awaited_verdicts.size(), typed ? typed_verdict : v);
    endtask

    // Lets every outstanding request finish; clear and load leave no result behind.
    task automatic wait_until_idle();
        i_in_valid <= 1'b0;
        while (awaited_verdicts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_threshold(input logic [THR_W-1:0] value);
        wait_until_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        threshold = value;
        i_cfg_we  <= 1'b0;
    endtask

    // A lone request, or maybe a clear, loads that may overfill the store, then queries.
    task automatic random_sequence();
        int loads;
        int queries;
        t_box b;
        gaps_on = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 7) == 0) begin
            issue_request(2'($urandom_range(0, 3)), random_box(), 1'b0, '0);
            return;
        end
        if ($urandom_range(0, 1) == 1)
            issue_request(MODE_CLEAR, random_box(), 1'b0, '0);
        loads = ($urandom_range(0, 5) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 8);
        repeat (loads) issue_request(MODE_LOAD, random_box(), 1'b0, '0);
        queries = $urandom_range(1, 6);
        repeat (queries) begin
            if (ref_total > 0 && $urandom_range(0, 1) == 1)
                b = jittered_box(ref_store[$urandom_range(0, ref_total - 1)]);
            else
                b = random_box();
            issue_request(MODE_QUERY, b, 1'b0, '0);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (awaited_verdicts.size() == 0) begin
                $display("%0t: unexpected result, suppressed %0d refs_checked %0d",
                         $time, o_suppressed, o_refs_checked);
                mismatches++;
            end else begin
                if (o_suppressed !== awaited_verdicts[0].suppressed) begin
                    $display("%0t: suppressed expected %0d got %0d",
                             $time, awaited_verdicts[0].suppressed, o_suppressed);
                    mismatches++;
                end
                if (o_refs_checked !== awaited_verdicts[0].refs) begin
                    $display("%0t: refs_checked expected %0d got %0d",
                             $time, awaited_verdicts[0].refs, o_refs_checked);
                    mismatches++;
                end
                void'(awaited_verdicts.pop_front());
            end
            sink_wait = gaps_on ? $urandom_range(0, 7) : 0;
        end else if (sink_wait > 0) begin
            sink_wait--;
        end
        i_out_stall <= (sink_wait > 0);
    end

    initial begin
        #20_000_000;
        $display("[box_overlap_suppress_filter] ERROR");
        $finish;
    end

    initial begin
        // Threshold is at its reset value of one half throughout the directed rows.
        directed_rows = '{
            '{MODE_QUERY, '{16'h0000, 16'h0000, 15'd5, 15'd5}, 1'b1, '{1'b0, 6'd0}},
            '{MODE_UNUSED, '{16'h8000, 16'h7FFF, 15'h7FFF, 15'h7FFF}, 1'b0, '{1'b0, 6'd0}},
            '{MODE_QUERY, '{16'h0000, 16'h0000, 15'd10, 15'd10}, 1'b1, '{1'b0, 6'd0}},
            '{MODE_LOAD,  '{16'h0000, 16'h0000, 15'd10, 15'd10}, 1'b0, '{1'b0, 6'd0}},
            '{MODE_QUERY, '{16'h0000, 16'h0000, 15'd10, 15'd10}, 1'b1, '{1'b1, 6'd1}},
            '{MODE_QUERY, '{16'd100, 16'd100, 15'd5, 15'd5}, 1'b1, '{1'b0, 6'd1}},
            '{MODE_LOAD,  '{16'h0000, 16'h0000, 15'd0, 15'd10}, 1'b0, '{1'b0, 6'd0}},
            '{MODE_QUERY, '{16'h0000, 16'h0000, 15'd10, 15'd10}, 1'b1, '{1'b1, 6'd2}},
            '{MODE_QUERY, '{16'h0000, 16'h0000, 15'd0, 15'd5}, 1'b1, '{1'b0, 6'd2}},
            '{MODE_LOAD,  '{16'h8000, 16'h8000, 15'h7FFF, 15'h7FFF}, 1'b0, '{1'b0, 6'd0}},
            '{MODE_QUERY, '{16'h7FFF, 16'h7FFF, 15'h7FFF, 15'h7FFF}, 1'b0, '{1'b0, 6'd0}},
            '{MODE_QUERY, '{16'h8000, 16'h8000, 15'h7FFF, 15'h7FFF}, 1'b1, '{1'b1, 6'd3}},
            '{MODE_QUERY, '{16'd5, 16'd0, 15'd10, 15'd10}, 1'b0, '{1'b0, 6'd0}},
            '{MODE_QUERY, '{16'd4, 16'd0, 15'd10, 15'd10}, 1'b0, '{1'b0, 6'd0}},
            '{MODE_QUERY, '{16'hFFFB, 16'hFFFB, 15'd20, 15'd20}, 1'b0, '{1'b0, 6'd0}},
            '{MODE_CLEAR, '{16'h7FFF, 16'h8000, 15'd0, 15'h7FFF}, 1'b0, '{1'b0, 6'd0}},
            '{MODE_QUERY, '{16'h0000, 16'h0000, 15'd10, 15'd10}, 1'b1, '{1'b0, 6'd0}},
            '{MODE_LOAD,  '{16'h7FFF, 16'h8000, 15'd0, 15'd0}, 1'b0, '{1'b0, 6'd0}},
            '{MODE_QUERY, '{16'h7FFF, 16'h8000, 15'h7FFF, 15'h7FFF}, 1'b1, '{1'b0, 6'd1}},
            '{MODE_LOAD,  '{16'h0000, 16'h0000, 15'd1, 15'd1}, 1'b0, '{1'b0, 6'd0}},
            '{MODE_QUERY, '{16'h0000, 16'h0000, 15'd1, 15'd1}, 1'b0, '{1'b0, 6'd0}}
        };
        thr_plan = '{0, 65536, 65535, 1, $urandom_range(0, 65536), 49152,
                     $urandom_range(0, 65536), 16384};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
            issue_request(directed_rows[i].mode, directed_rows[i].box,
                          directed_rows[i].typed, directed_rows[i].verdict);

        for (int p = 0; p < THR_PHASES; p++) begin
            int unsigned target;
            set_threshold(thr_plan[p][THR_W-1:0]);
            target = sent_items + PHASE_ITEMS;
            while (sent_items < target) random_sequence();
        end

        wait_until_idle();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0)
            $display("[box_overlap_suppress_filter] OK");
        else
            $display("[box_overlap_suppress_filter] ERROR");
        $finish;
    end

endmodule

### files.f
+incdir+src
src/bosf_pkg.sv
src/bosf_ref_mem.sv
src/bosf_overlap_unit.sv
src/box_overlap_suppress_filter.sv
dv/tb.sv
